### hdl/hbc_pkg.sv
// Shared types and constants of the hashed buffer cache.
`default_nettype none
package hbc_pkg;

  localparam int SLOTS_DEF   = 32;
  localparam int BUCKETS_DEF = 13;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_REL   = 2'd1,
    OP_PIN   = 2'd2,
    OP_UNPIN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOFREE = 2'd1,
    STS_RANGE  = 2'd2
  } status_t;

  // One slot of the tag table, as stored in one memory word.
  typedef struct packed {
    logic [3:0]  bucket;
    logic [31:0] dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic [31:0] rtime;
    logic        valid;
    logic [31:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### hdl/hashed_buffer_cache_lru.sv
// Hashed buffer cache tag table with timestamp LRU replacement, top level.
// The slave channel (in_*) takes one request per beat: in_tuser is the
// operation (get, release, pin, unpin) and in_tdata holds device, block
// number, slot and the current tick. The master channel (out_*) returns
// one beat per request with slot, needs-read flag and status.
// After reset the block runs a clearing pass over the slot memory, one
// slot per cycle, with in_tready low. Release, pin and unpin do one
// memory read, one read-modify-write (skipped for an out-of-range slot)
// and then load the output register. A get accepts the request and
// starts the bucket remainder, waits for the remainder, scans the slot
// memory (one slot read per cycle through its single read port), runs
// the ring search over per-bucket oldest free slots, up to BUCKETS
// buckets, when the scan found no hit, and then loads the output register.
// One request is in flight at a time. The output register holds a result
// while the receiver stalls; the next request is still accepted, and its
// result waits until the held beat is taken.
`default_nettype none
module hashed_buffer_cache_lru import hbc_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // device[31:0], block_number[63:32], slot_in[68:64], now[100:69], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // slot_out[4:0], needs_read[5], status[7:6]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_MOD  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_RING = 7'b0010000,
    S_SOP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r;

  logic [1:0]  op_r;
  logic [31:0] dev_r, blk_r, now_r;
  logic [4:0]  sin_r;
  logic [BW-1:0] home_r;
  logic [SW:0]   cnt_r;
  logic          scan_vld_r;
  logic [SW-1:0] scan_idx_r;
  logic          hit_vld_r;
  logic [SW-1:0] hit_slot_r;
  entry_t        hit_ent_r;
  logic          best_vld_r [BUCKETS];
  logic [SW-1:0] best_slot_r [BUCKETS];
  logic [31:0]   best_rt_r [BUCKETS];
  logic [31:0]   best_ord_r [BUCKETS];
  logic [BW-1:0] ring_b_r;
  logic [BW-1:0] ring_k_r;
  logic [31:0]   order_ctr_r;
  logic [4:0]    res_slot_r;
  logic          res_nr_r;
  logic [1:0]    res_st_r;
  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rword;

  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;

  logic [4:0]  in_slot;
  logic        in_acc;
  logic        in_range;

  assign in_slot   = in_tdata[68:64];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = (9'(in_slot) < 9'(SLOTS));
  assign mod_start = in_acc && (op_t'(in_tuser) == OP_GET);
  assign ram_rdata = entry_t'(ram_rword);

  hbc_mod #(.BUCKETS(BUCKETS), .BW(BW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (in_tdata[63:32]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  hbc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS), .AW(SW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rword)
  );

  assign ram_raddr = (state_r == S_IDLE) ? SW'(in_slot) : cnt_r[SW-1:0];

  // Memory writes: clearing pass, get refill or hit update, slot count update.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[SW-1:0];
    ram_wdata = '0;
    case (state_r)
      S_CLR: begin
        ram_we          = 1'b1;
        ram_wdata.order = 32'(cnt_r);
      end
      S_RING: begin
        if (hit_vld_r) begin
          ram_waddr = hit_slot_r;
          ram_wdata = hit_ent_r;
          ram_wdata.cnt   = hit_ent_r.cnt + 8'd1;
          ram_wdata.valid = 1'b1;
          ram_we = (hit_ent_r.cnt != CNT_MAX);
        end else if (best_vld_r[ring_b_r]) begin
          ram_we          = 1'b1;
          ram_waddr       = best_slot_r[ring_b_r];
          ram_wdata.bucket = 4'(home_r);
          ram_wdata.dev   = dev_r;
          ram_wdata.blk   = blk_r;
          ram_wdata.cnt   = 8'd1;
          ram_wdata.rtime = best_rt_r[ring_b_r];
          ram_wdata.valid = 1'b1;
          ram_wdata.order = (ring_k_r == '0) ? best_ord_r[ring_b_r] : order_ctr_r;
        end
      end
      S_SOP: begin
        ram_waddr = SW'(sin_r);
        ram_wdata = ram_rdata;
        if (op_t'(op_r) == OP_PIN) begin
          ram_wdata.cnt = ram_rdata.cnt + 8'd1;
          ram_we = (ram_rdata.cnt != CNT_MAX);
        end else begin
          ram_wdata.cnt = ram_rdata.cnt - 8'd1;
          ram_we = (ram_rdata.cnt != 8'd0);
          if (op_t'(op_r) == OP_REL && ram_rdata.cnt == 8'd1) begin
            ram_wdata.rtime = now_r;
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      scan_vld_r  <= 1'b0;
      hit_vld_r   <= 1'b0;
      order_ctr_r <= 32'(SLOTS);
      out_valid_r <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        best_vld_r[b] <= 1'b0;
      end
    end else begin
      // In S_DONE the output register is either reloaded or left holding.
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (SW+1)'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r  <= in_tuser;
            dev_r <= in_tdata[31:0];
            blk_r <= in_tdata[63:32];
            sin_r <= in_slot;
            now_r <= in_tdata[100:69];
            res_slot_r <= in_slot;
            res_nr_r   <= 1'b0;
            res_st_r   <= STS_RANGE;
            if (op_t'(in_tuser) == OP_GET) begin
              state_r <= S_MOD;
            end else if (in_range) begin
              state_r <= S_SOP;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            home_r     <= mod_rem;
            ring_b_r   <= mod_rem;
            ring_k_r   <= '0;
            cnt_r      <= '0;
            scan_vld_r <= 1'b0;
            hit_vld_r  <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
              best_vld_r[b] <= 1'b0;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx_r <= cnt_r[SW-1:0];
          if (cnt_r == (SW+1)'(SLOTS)) begin
            scan_vld_r <= 1'b0;
            state_r    <= S_RING;
          end else begin
            scan_vld_r <= 1'b1;
            cnt_r      <= cnt_r + 1'b1;
          end
          if (scan_vld_r) begin
            if (ram_rdata.bucket == 4'(home_r) && ram_rdata.dev == dev_r &&
                ram_rdata.blk == blk_r &&
                (!hit_vld_r || ram_rdata.order > hit_ent_r.order)) begin
              hit_vld_r  <= 1'b1;
              hit_slot_r <= scan_idx_r;
              hit_ent_r  <= ram_rdata;
            end
            // One comparator lane per bucket keeps that bucket's oldest free slot.
            for (int b = 0; b < BUCKETS; b++) begin
              if (ram_rdata.cnt == 8'd0 && ram_rdata.bucket == 4'(b) &&
                  (!best_vld_r[b] || ram_rdata.rtime < best_rt_r[b] ||
                   (ram_rdata.rtime == best_rt_r[b] &&
                    ram_rdata.order > best_ord_r[b]))) begin
                best_vld_r[b]  <= 1'b1;
                best_slot_r[b] <= scan_idx_r;
                best_rt_r[b]   <= ram_rdata.rtime;
                best_ord_r[b]  <= ram_rdata.order;
              end
            end
          end
        end
        S_RING: begin
          if (hit_vld_r) begin
            res_slot_r <= 5'(hit_slot_r);
            if (hit_ent_r.cnt == CNT_MAX) begin
              res_st_r <= STS_RANGE;
            end else begin
              res_st_r <= STS_OK;
              res_nr_r <= !hit_ent_r.valid;
            end
            state_r <= S_DONE;
          end else if (best_vld_r[ring_b_r]) begin
            res_slot_r <= 5'(best_slot_r[ring_b_r]);
            res_st_r   <= STS_OK;
            res_nr_r   <= 1'b1;
            if (ring_k_r != '0) begin
              order_ctr_r <= order_ctr_r + 32'd1;
            end
            state_r <= S_DONE;
          end else if (ring_k_r == BW'(BUCKETS - 1)) begin
            res_slot_r <= '0;
            res_st_r   <= STS_NOFREE;
            state_r    <= S_DONE;
          end else begin
            ring_k_r <= ring_k_r + 1'b1;
            ring_b_r <= (ring_b_r == BW'(BUCKETS - 1)) ? '0 : ring_b_r + 1'b1;
          end
        end
        S_SOP: begin
          if (op_t'(op_r) == OP_PIN) begin
            res_st_r <= (ram_rdata.cnt == CNT_MAX) ? STS_RANGE : STS_OK;
          end else begin
            res_st_r <= (ram_rdata.cnt == 8'd0) ? STS_RANGE : STS_OK;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res_st_r, res_nr_r, res_slot_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### hdl/hbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/hbc_mod.sv
// Bucket remainder unit: value mod BUCKETS; registered nibble sum, remainder.
`default_nettype none
module hbc_mod import hbc_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   value,
  output logic               done,
  output logic [BW-1:0]      rem
);

  // Each nibble is weighted by 16**k mod BUCKETS, so the weighted sum keeps
  // the residue and stays below 2**11 (8 nibbles, 15 times 15 at most).
  localparam int SUM_W = 11;
  localparam int QSH   = SUM_W + 4;
  localparam int RECIP = (2**QSH + BUCKETS - 1) / BUCKETS;
  localparam int RCP_W = QSH + 1;
  localparam int PRD_W = SUM_W + RCP_W;

  function automatic logic [31:0] nib_weights();
    logic [31:0] v;
    int w;
    v = '0;
    w = 1 % BUCKETS;
    for (int k = 0; k < 8; k++) begin
      v[4*k +: 4] = 4'(w);
      w = (w * 16) % BUCKETS;
    end
    return v;
  endfunction

  localparam logic [31:0] WGT = nib_weights();

  logic [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0] sum_r;
  logic [PRD_W-1:0] prd;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] rem_c;
  logic             stg_r;
  logic             done_r;
  logic [BW-1:0]    rem_r;

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < 8; k++) begin
      sum_c = sum_c + SUM_W'(value[4*k +: 4]) * SUM_W'(WGT[4*k +: 4]);
    end
  end

  // The scaled reciprocal is exact for every sum below 2**11.
  assign prd   = PRD_W'(sum_r) * PRD_W'(RECIP);
  assign quo   = prd[QSH +: SUM_W];
  assign rem_c = sum_r - quo * SUM_W'(BUCKETS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= start;
      done_r <= stg_r;
      if (start) begin
        sum_r <= sum_c;
      end
      if (stg_r) begin
        rem_r <= rem_c[BW-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### hdl/hbc_checker.sv
// Port-level assertions for the hashed buffer cache, bound to the top level.
`default_nettype none
module hbc_checker import hbc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_nofree_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] == STS_NOFREE |-> out_tdata[5:0] == 6'd0)
    else $error("no-free result carries slot or read flag");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[7:6] == STS_OK)
    else $error("read request on a failed result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in flight");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

endmodule

bind hashed_buffer_cache_lru hbc_checker u_hbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the hashed buffer cache tag table with LRU replacement.
`default_nettype none
module tb;
  import hbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 32;
  localparam int NBKT  = 13;
  localparam longint LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [4:0] slot;
    logic       nread;
    status_t    sts;
  } cache_reply_t;

  // Shadow copy of the tag table that works out the reply of each request.
  class cache_scoreboard;
    logic [3:0]  bkt [NSLOT];
    logic [31:0] dev [NSLOT];
    logic [31:0] blk [NSLOT];
    logic [7:0]  cnt [NSLOT];
    logic [31:0] rtm [NSLOT];
    logic        vld [NSLOT];
    logic [31:0] ord [NSLOT];
    logic [31:0] ord_ctr;
    cache_reply_t pending[$];
    int errors;
    int checked;
    int hits, misses, moves, nofree, ranges;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        bkt[i] = '0; dev[i] = '0; blk[i] = '0; cnt[i] = '0;
        rtm[i] = '0; vld[i] = 1'b0; ord[i] = i;
      end
      ord_ctr = NSLOT;
    endfunction

    function int oldest_free(int b);
      int pick;
      pick = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (bkt[i] != b || cnt[i] != 0) continue;
        if (pick < 0 || rtm[i] < rtm[pick] || (rtm[i] == rtm[pick] && ord[i] > ord[pick]))
          pick = i;
      end
      return pick;
    endfunction

    function void note_request(op_t op, logic [31:0] d, logic [31:0] b, logic [4:0] s,
                               logic [31:0] now);
      cache_reply_t r;
      int hit, pick, home;
      r = '{slot: 5'd0, nread: 1'b0, sts: STS_OK};
      if (op == OP_GET) begin
        home = b % NBKT;
        hit = -1;
        for (int i = 0; i < NSLOT; i++)
          if (bkt[i] == home && dev[i] == d && blk[i] == b && (hit < 0 || ord[i] > ord[hit]))
            hit = i;
        if (hit >= 0) begin
          hits++;
          r.slot = 5'(hit);
          if (cnt[hit] == CNT_MAX) begin
            r.sts = STS_RANGE;
          end else begin
            cnt[hit]++;
            r.nread = !vld[hit];
            vld[hit] = 1'b1;
          end
        end else begin
          pick = oldest_free(home);
          if (pick < 0) begin
            for (int k = 1; k < NBKT; k++) begin
              pick = oldest_free((home + k) % NBKT);
              if (pick >= 0) break;
            end
            if (pick >= 0) begin
              moves++;
              bkt[pick] = 4'(home);
              ord[pick] = ord_ctr;
              ord_ctr++;
            end
          end
          if (pick < 0) begin
            nofree++;
            r.sts = STS_NOFREE;
          end else begin
            misses++;
            r.slot = 5'(pick);
            cnt[pick] = 8'd1; dev[pick] = d; blk[pick] = b;
            r.nread = 1'b1; vld[pick] = 1'b1;
          end
        end
      end else begin
        r.slot = s;
        if (op == OP_PIN) begin
          if (cnt[s] == CNT_MAX) r.sts = STS_RANGE;
          else cnt[s]++;
        end else if (cnt[s] == 0) begin
          r.sts = STS_RANGE;
        end else begin
          cnt[s]--;
          if (op == OP_REL && cnt[s] == 0) rtm[s] = now;
        end
        if (r.sts == STS_RANGE) ranges++;
      end
      pending.push_back(r);
    endfunction

    function void check_reply(logic [7:0] data);
      cache_reply_t exp_r, got;
      got.slot = data[4:0];
      got.nread = data[5];
      got.sts = status_t'(data[7:6]);
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected reply %h", data);
        return;
      end
      exp_r = pending.pop_front();
      if (got.slot !== exp_r.slot || got.nread !== exp_r.nread || got.sts !== exp_r.sts) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: reply %0d expected slot %0d nread %0d status %0d, got %0d %0d %0d",
                   checked, exp_r.slot, exp_r.nread, exp_r.sts, got.slot, got.nread, data[7:6]);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  hashed_buffer_cache_lru uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  cache_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_reply(out_tdata);
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each call is entered at a rising edge; the beat is held until accepted.
  task automatic send(op_t op, logic [31:0] d, logic [31:0] b, logic [4:0] s,
                      logic [31:0] now);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[31:0] = d;
    word[63:32] = b;
    word[68:64] = s;
    word[100:69] = now;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, d, b, s, now);
  endtask

  // Mostly a working set of blocks, with random gets, releases, pins and unpins.
  task automatic random_request();
    logic [31:0] d, b, now;
    int r;
    op_t op;
    r = $urandom_range(99);
    now = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
    d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2);
    b = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
    if (r < 45) op = OP_GET;
    else if (r < 80) op = OP_REL;
    else if (r < 88) op = OP_PIN;
    else op = OP_UNPIN;
    send(op, d, b, 5'($urandom_range(NSLOT - 1)), now);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_GET;
    hold_off = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 45;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fresh miss, hit, extremes, underflow, overflow, moves between buckets.
    send(OP_GET, 32'h0, 32'h0, '0, 0);
    send(OP_GET, 32'h0, 32'h0, '0, 0);
    send(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 0);
    send(OP_REL, 0, 0, 5'd31, 32'hFFFF_FFFF);
    send(OP_UNPIN, 0, 0, 5'd3, 0);
    send(OP_REL, 0, 0, 5'd31, 32'hFFFF_FFFF);
    send(OP_PIN, 0, 0, 5'd31, 0);
    send(OP_UNPIN, 0, 0, 5'd31, 0);
    send(OP_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send(OP_GET, 32'h5, 32'd13, '0, 0);
    send(OP_GET, 32'h5, 32'd7, '0, 0);
    for (int i = 0; i < 256; i++) send(OP_PIN, 0, 0, 5'd4, 0);
    send(OP_GET, 32'h1234_5678, 32'h8765_4321, '0, 0);
    // Fill every slot so the next get finds nothing free.
    for (int i = 0; i < NSLOT; i++) send(OP_GET, 32'h77, 100 + i, '0, 0);
    send(OP_GET, 32'h78, 32'd1, '0, 0);
    for (int i = 0; i < NSLOT; i++) send(OP_REL, 0, 0, 5'(i), $urandom_range(5));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 33 : 0;
      for (int n = 0; n < 470; n++) begin
        if (ph == 2 && n == 100) hold_off = 1'b1;
        random_request();
      end
    end
    in_tvalid <= 1'b0;
    hold_off = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d replies: %0d hits, %0d refills (%0d from other buckets),",
             sb.checked, sb.hits, sb.misses, sb.moves);
    $display("%0d no-free replies and %0d count range errors.", sb.nofree, sb.ranges);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Releases the long receiver hold-off after a fixed stretch.
  initial begin
    wait (hold_off);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end
endmodule
`default_nettype wire
